>>> rtl/gclp_pkg.sv
package gclp_pkg;

   // Line and value geometry.
   localparam int NameChars    = 4;
   localparam int ValueBits    = 32;
   localparam int CommandCount = 10;
   localparam int FieldCount   = 6;
   localparam int FieldWidth   = 32;
   localparam int LenWidth     = $clog2(NameChars + 2);
   localparam int NameIdxWidth = $clog2(NameChars);
   localparam int IndexWidth   = 4;
   localparam int DigitCount   = 10;

   // Character codes.
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;

   // Field letters.
   localparam logic [7:0] CharX = 8'h58;
   localparam logic [7:0] CharY = 8'h59;
   localparam logic [7:0] CharZ = 8'h5A;
   localparam logic [7:0] CharE = 8'h45;
   localparam logic [7:0] CharF = 8'h46;
   localparam logic [7:0] CharS = 8'h53;

   // Token phase codes.
   localparam logic [1:0] PhaseNone  = 2'd0;
   localparam logic [1:0] PhaseName  = 2'd1;
   localparam logic [1:0] PhaseField = 2'd2;

   // Number scan phase codes.
   localparam logic [1:0] NumSkip   = 2'd0;
   localparam logic [1:0] NumSign   = 2'd1;
   localparam logic [1:0] NumDigits = 2'd2;
   localparam logic [1:0] NumDone   = 2'd3;

   // Field slots, in used-mask bit order.
   localparam int SlotX = 0;
   localparam int SlotY = 1;
   localparam int SlotZ = 2;
   localparam int SlotE = 3;
   localparam int SlotF = 4;
   localparam int SlotS = 5;

   // Saturation limits: the magnitude of the most negative value, and the largest
   // accumulator that still takes one more digit d without passing that magnitude.
   localparam logic [ValueBits-1:0] MagLimit = {1'b1, {(ValueBits - 1){1'b0}}};
   localparam logic [ValueBits-1:0] PosLimit = {1'b0, {(ValueBits - 1){1'b1}}};
   localparam logic [ValueBits-1:0] DigitLimit [DigitCount] = '{
      (MagLimit - ValueBits'(0)) / 10, (MagLimit - ValueBits'(1)) / 10,
      (MagLimit - ValueBits'(2)) / 10, (MagLimit - ValueBits'(3)) / 10,
      (MagLimit - ValueBits'(4)) / 10, (MagLimit - ValueBits'(5)) / 10,
      (MagLimit - ValueBits'(6)) / 10, (MagLimit - ValueBits'(7)) / 10,
      (MagLimit - ValueBits'(8)) / 10, (MagLimit - ValueBits'(9)) / 10
   };

   // Command name table: G1, G28, G90, G91, G92, M104, M109, M140, M190, M106.
   localparam logic [7:0] CmdText [CommandCount][NameChars] = '{
      '{8'h47, 8'h31, 8'h00, 8'h00},
      '{8'h47, 8'h32, 8'h38, 8'h00},
      '{8'h47, 8'h39, 8'h30, 8'h00},
      '{8'h47, 8'h39, 8'h31, 8'h00},
      '{8'h47, 8'h39, 8'h32, 8'h00},
      '{8'h4D, 8'h31, 8'h30, 8'h34},
      '{8'h4D, 8'h31, 8'h30, 8'h39},
      '{8'h4D, 8'h31, 8'h34, 8'h30},
      '{8'h4D, 8'h31, 8'h39, 8'h30},
      '{8'h4D, 8'h31, 8'h30, 8'h36}
   };
   localparam logic [LenWidth-1:0] CmdLen [CommandCount] = '{
      LenWidth'(2), LenWidth'(3), LenWidth'(3), LenWidth'(3), LenWidth'(3),
      LenWidth'(4), LenWidth'(4), LenWidth'(4), LenWidth'(4), LenWidth'(4)
   };

   // Command name as seen at the end of a line.
   typedef struct packed {
      logic                          any_token;
      logic [LenWidth-1:0]           name_len;
      logic [NameChars-1:0][7:0]     name_chars;
   } name_info_type;

   // Outcome of the name lookup.
   typedef struct packed {
      logic                  found;
      logic [IndexWidth-1:0] index;
   } cmd_match_type;

   typedef logic [FieldCount-1:0][ValueBits-1:0] field_values_type;

endpackage

>>> rtl/gclp_match.sv
module gclp_match (
   input  gclp_pkg::name_info_type name_info,
   output gclp_pkg::cmd_match_type cmd_match
);
   import gclp_pkg::*;

   logic [CommandCount-1:0] hit;

   // Compare the collected name with every table entry.
   always_comb begin
      for (int i = 0; i < CommandCount; i++) begin
         hit[i] = name_info.any_token && (name_info.name_len == CmdLen[i]);
         for (int j = 0; j < NameChars; j++) begin
            if ((LenWidth'(j) < CmdLen[i]) && (name_info.name_chars[j] != CmdText[i][j])) begin
               hit[i] = 1'b0;
            end
         end
      end
   end

   // Encode the first matching entry.
   always_comb begin
      cmd_match.found = |hit;
      cmd_match.index = '0;
      for (int i = CommandCount - 1; i >= 0; i--) begin
         if (hit[i]) begin
            cmd_match.index = IndexWidth'(i);
         end
      end
   end

endmodule

>>> rtl/gclp_scan.sv
module gclp_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 line_byte,
   input  logic                       line_end,
   output gclp_pkg::name_info_type    name_info,
   output logic [gclp_pkg::FieldCount-1:0] used_mask,
   output gclp_pkg::field_values_type field_values
);
   import gclp_pkg::*;

   logic [1:0]                  phase_ff, phase_in;
   logic                        inside_ff, inside_in;
   logic [NameChars-1:0][7:0]   name_ff, name_in;
   logic [LenWidth-1:0]         len_ff, len_in;
   logic [7:0]                  letter_ff, letter_in;
   logic [1:0]                  num_phase_ff, num_phase_in;
   logic                        neg_ff, neg_in;
   logic [ValueBits-1:0]        acc_ff, acc_in;
   field_values_type            field_ff, field_in;
   logic [FieldCount-1:0]       present_ff, present_in;

   logic                        is_digit;
   logic [3:0]                  digit;
   logic [ValueBits-1:0]        acc_digit;
   logic                        end_now;
   logic [FieldCount-1:0]       slot_hit;
   logic [ValueBits-1:0]        token_value;

   // Digit decode and the saturating multiply-by-ten add.
   always_comb begin
      is_digit = (line_byte inside {[CharZero:CharNine]});
      digit    = 4'(line_byte - CharZero);
      if (acc_ff > DigitLimit[digit]) begin
         acc_digit = MagLimit;
      end else begin
         acc_digit = acc_ff * ValueBits'(10) + ValueBits'(digit);
      end
   end

   // Token scan for the current byte.
   always_comb begin
      phase_in     = phase_ff;
      inside_in    = inside_ff;
      name_in      = name_ff;
      len_in       = len_ff;
      letter_in    = letter_ff;
      num_phase_in = num_phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      end_now      = 1'b0;
      if (line_byte == CharSpace) begin
         end_now   = inside_ff;
         inside_in = 1'b0;
      end else if (!inside_ff) begin
         inside_in = 1'b1;
         if (phase_ff == PhaseNone) begin
            phase_in   = PhaseName;
            name_in[0] = line_byte;
            len_in     = LenWidth'(1);
         end else begin
            phase_in     = PhaseField;
            letter_in    = line_byte;
            num_phase_in = NumSkip;
            neg_in       = 1'b0;
            acc_in       = '0;
         end
      end else if (phase_ff == PhaseName) begin
         if (len_ff < LenWidth'(NameChars)) begin
            name_in[len_ff[NameIdxWidth-1:0]] = line_byte;
         end
         if (len_ff <= LenWidth'(NameChars)) begin
            len_in = len_ff + LenWidth'(1);
         end
      end else begin
         case (num_phase_ff)
            NumSkip: begin
               if (line_byte inside {[CharTab:CharCr]}) begin
                  num_phase_in = NumSkip;
               end else if (line_byte == CharPlus || line_byte == CharMinus) begin
                  neg_in       = (line_byte == CharMinus);
                  num_phase_in = NumSign;
               end else if (is_digit) begin
                  acc_in       = acc_digit;
                  num_phase_in = NumDigits;
               end else begin
                  num_phase_in = NumDone;
               end
            end
            NumSign, NumDigits: begin
               if (is_digit) begin
                  acc_in       = acc_digit;
                  num_phase_in = NumDigits;
               end else begin
                  num_phase_in = NumDone;
               end
            end
            default: begin
               num_phase_in = num_phase_ff;
            end
         endcase
      end
      if (line_end && inside_in) begin
         end_now = 1'b1;
      end
   end

   // Close a field token: pick its slot and its saturated value.
   always_comb begin
      slot_hit = '0;
      case (letter_in)
         CharX:   slot_hit[SlotX] = 1'b1;
         CharY:   slot_hit[SlotY] = 1'b1;
         CharZ:   slot_hit[SlotZ] = 1'b1;
         CharE:   slot_hit[SlotE] = 1'b1;
         CharF:   slot_hit[SlotF] = 1'b1;
         CharS:   slot_hit[SlotS] = 1'b1;
         default: slot_hit = '0;
      endcase
      if (neg_in) begin
         token_value = '0 - acc_in;
      end else if (acc_in > PosLimit) begin
         token_value = PosLimit;
      end else begin
         token_value = acc_in;
      end
      field_in   = field_ff;
      present_in = present_ff;
      if (end_now && phase_in == PhaseField) begin
         for (int k = 0; k < FieldCount; k++) begin
            if (slot_hit[k]) begin
               field_in[k]   = token_value;
               present_in[k] = 1'b1;
            end
         end
      end
   end

   // Line summary as it stands after this byte.
   always_comb begin
      name_info.any_token  = (phase_in != PhaseNone);
      name_info.name_len   = len_in;
      name_info.name_chars = name_in;
      used_mask            = present_in;
      for (int k = 0; k < FieldCount; k++) begin
         field_values[k] = present_in[k] ? field_in[k] : '0;
      end
   end

   // Control state; everything returns to its start values after the last byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhaseNone;
         inside_ff    <= 1'b0;
         len_ff       <= '0;
         num_phase_ff <= NumSkip;
         neg_ff       <= 1'b0;
         present_ff   <= '0;
      end else if (step) begin
         if (line_end) begin
            phase_ff     <= PhaseNone;
            inside_ff    <= 1'b0;
            len_ff       <= '0;
            num_phase_ff <= NumSkip;
            neg_ff       <= 1'b0;
            present_ff   <= '0;
         end else begin
            phase_ff     <= phase_in;
            inside_ff    <= inside_in;
            len_ff       <= len_in;
            num_phase_ff <= num_phase_in;
            neg_ff       <= neg_in;
            present_ff   <= present_in;
         end
      end
   end

   // Payload state; only read where the control state marks it meaningful.
   always_ff @(posedge clock) begin
      if (step) begin
         name_ff   <= name_in;
         letter_ff <= letter_in;
         acc_ff    <= line_end ? '0 : acc_in;
         field_ff  <= field_in;
      end
   end

endmodule

>>> rtl/gcode_line_field_parser.sv
// Channel   Dir  tdata                                   tuser  tlast
// req_      in   [7:0] line_byte                         -      line_end
// rsp_      out  status, command_index, used_mask,       -      -
//                x/y/z/e/f/s values (32 bits each)
//
// One request byte is taken every cycle while no final byte waits for the output
// register; a byte is scanned while it sits in the input register, and the line
// result is loaded into the output register at the same edge that retires the
// final byte, and is offered from that register.
// The per-byte path is one saturating multiply-by-ten add and the field select.
// Only a final byte waits for the output register; other bytes never stall.
// Reset is synchronous and returns the scanner to the start of a line.
module gcode_line_field_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] line_byte
   input  logic         req_tlast,   // line_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] status, [4:1] command_index, [10:5] used_mask, [42:11] x_value,
   // [74:43] y_value, [106:75] z_value, [138:107] e_value, [170:139] f_value,
   // [202:171] s_value, [207:203] zero
   output logic [207:0] rsp_tdata
);
   import gclp_pkg::*;

   localparam int DataBits = 1 + IndexWidth + FieldCount + FieldCount * FieldWidth;
   localparam int PadBits  = 208 - DataBits;

   logic                  in_valid_ff;
   logic [7:0]            byte_ff;
   logic                  last_ff;
   logic                  advance;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [207:0]          rsp_data_ff, rsp_data_in;

   name_info_type         name_info;
   cmd_match_type         cmd_match;
   logic [FieldCount-1:0] used_mask;
   field_values_type      field_values;
   logic [FieldCount*FieldWidth-1:0] value_bits;

   // A byte moves on unless it ends a line and the result slot is still full.
   assign advance    = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   gclp_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .line_byte    (byte_ff),
      .line_end     (last_ff),
      .name_info    (name_info),
      .used_mask    (used_mask),
      .field_values (field_values)
   );

   gclp_match u_match (
      .name_info (name_info),
      .cmd_match (cmd_match)
   );

   // Result packing; an unknown name clears every field.
   always_comb begin
      for (int k = 0; k < FieldCount; k++) begin
         value_bits[k*FieldWidth +: FieldWidth] = FieldWidth'($signed(field_values[k]));
      end
      if (cmd_match.found) begin
         rsp_data_in = {{PadBits{1'b0}}, value_bits, used_mask, cmd_match.index, 1'b0};
      end else begin
         rsp_data_in = {{(208 - 1){1'b0}}, 1'b1};
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/gcode_line_field_parser_tb.sv
module gcode_line_field_parser_tb;

   localparam int NAME_CHARS    = 4;
   localparam int COMMAND_COUNT = 10;
   localparam int FIELD_COUNT   = 6;
   localparam int ITEM_COUNT    = 1650;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_REPORTS   = 100;

   // Character codes seen by the scanner.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Field letters in used-mask order; entry 0 is X.
   localparam logic [FIELD_COUNT-1:0][7:0] FIELD_LETTERS = "SFEZYX";

   localparam logic        STATUS_OK      = 1'b0;
   localparam logic        STATUS_UNKNOWN = 1'b1;
   localparam logic [63:0] MAG_LIMIT      = 64'h8000_0000;

   typedef enum logic [1:0] {TOK_NONE, TOK_NAME, TOK_FIELD} token_phase_type;
   typedef enum logic [1:0] {NUM_SKIP, NUM_SIGN, NUM_DIGITS, NUM_DONE} number_phase_type;

   // One line result, packed the way the response data carries it.
   typedef struct packed {
      logic [FIELD_COUNT-1:0][31:0] values;
      logic [5:0]                   used_mask;
      logic [3:0]                   cmd_index;
      logic                         status;
   } line_result_type;

   typedef struct {
      logic [7:0] line_byte;
      bit         line_end;
   } line_request_type;

   // Parses the request bytes alongside the block and checks each line result.
   class gcode_line_predictor;
      line_result_type              expected_lines[$];
      int                           error_count;
      int                           line_count;
      string                        cmd_names[COMMAND_COUNT];
      token_phase_type              tok_phase;
      bit                           in_token;
      logic [7:0]                   name_buf[NAME_CHARS];
      int                           name_len;
      logic [7:0]                   letter;
      number_phase_type             num_phase;
      bit                           negative;
      logic [63:0]                  magnitude;
      logic [FIELD_COUNT-1:0][31:0] values;
      logic [5:0]                   present;

      function new();
         cmd_names = '{"G1", "G28", "G90", "G91", "G92",
                       "M104", "M109", "M140", "M190", "M106"};
         error_count = 0;
         line_count  = 0;
         clear_line();
      endfunction

      function void clear_line();
         tok_phase = TOK_NONE;
         in_token  = 0;
         foreach (name_buf[k]) name_buf[k] = CHAR_NUL;
         name_len  = 0;
         letter    = CHAR_NUL;
         num_phase = NUM_SKIP;
         negative  = 0;
         magnitude = '0;
         values    = '0;
         present   = '0;
      endfunction

      // Saturating multiply-by-ten add on the magnitude.
      function void add_digit(int unsigned d);
         if (magnitude > (MAG_LIMIT - d) / 10) begin
            magnitude = MAG_LIMIT;
         end else begin
            magnitude = magnitude * 10 + d;
         end
      endfunction

      // A field token ends: store its value if the letter names a field.
      function void close_token();
         logic [63:0] v;
         int          slot;
         int          k;
         if (tok_phase != TOK_FIELD) return;
         slot = FIELD_COUNT;
         for (k = 0; k < FIELD_COUNT; k++) begin
            if (letter == FIELD_LETTERS[k]) slot = k;
         end
         if (slot == FIELD_COUNT) return;
         if (negative) begin
            v = 64'd0 - magnitude;
         end else begin
            v = (magnitude > MAG_LIMIT - 1) ? MAG_LIMIT - 1 : magnitude;
         end
         values[slot]  = v[31:0];
         present[slot] = 1'b1;
      endfunction

      function void note_byte(logic [7:0] b, bit last);
         line_result_type res;
         int              found;
         int              i;
         int              k;
         bit              digit;
         bit              same;
         found = -1;
         digit = (b >= CHAR_ZERO && b <= CHAR_NINE);

         // Token boundaries, name collection and the atoi-style value scan.
         if (b == CHAR_SPACE) begin
            if (in_token) close_token();
            in_token = 0;
         end else if (!in_token) begin
            in_token = 1;
            if (tok_phase == TOK_NONE) begin
               tok_phase   = TOK_NAME;
               name_buf[0] = b;
               name_len    = 1;
            end else begin
               tok_phase = TOK_FIELD;
               letter    = b;
               num_phase = NUM_SKIP;
               negative  = 0;
               magnitude = '0;
            end
         end else if (tok_phase == TOK_NAME) begin
            if (name_len < NAME_CHARS) name_buf[name_len] = b;
            if (name_len <= NAME_CHARS) name_len++;
         end else if (num_phase == NUM_SKIP) begin
            // Whitespace before the sign or digits is passed over.
            if (b < CHAR_TAB || b > CHAR_CR) begin
               if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                  negative  = (b == CHAR_MINUS);
                  num_phase = NUM_SIGN;
               end else if (digit) begin
                  add_digit(b - CHAR_ZERO);
                  num_phase = NUM_DIGITS;
               end else begin
                  num_phase = NUM_DONE;
               end
            end
         end else if (num_phase != NUM_DONE) begin
            if (digit) begin
               add_digit(b - CHAR_ZERO);
               num_phase = NUM_DIGITS;
            end else begin
               num_phase = NUM_DONE;
            end
         end

         if (!last) return;
         if (in_token) close_token();

         // Look the name up in the command table.
         if (tok_phase != TOK_NONE) begin
            for (i = 0; i < COMMAND_COUNT; i++) begin
               if (found < 0 && name_len == cmd_names[i].len()) begin
                  same = 1;
                  for (k = 0; k < name_len; k++) begin
                     if (name_buf[k] != cmd_names[i][k]) same = 0;
                  end
                  if (same) found = i;
               end
            end
         end

         res = '0;
         if (found < 0) begin
            res.status = STATUS_UNKNOWN;
         end else begin
            res.status    = STATUS_OK;
            res.cmd_index = 4'(found);
            res.used_mask = present;
            res.values    = values;
         end
         expected_lines.push_back(res);
         clear_line();
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("ERROR line result %0d: %s", line_count, msg);
         end
      endtask

      task check_line(logic [207:0] tdata);
         line_result_type want;
         line_result_type got;
         int              k;
         line_count++;
         if (expected_lines.size() == 0) begin
            report($sformatf("result with no line pending, data %h", tdata));
            return;
         end
         want = expected_lines.pop_front();
         got  = tdata[202:0];
         if (got.status != want.status) begin
            report($sformatf("status got %0d expected %0d", got.status, want.status));
         end
         if (got.cmd_index != want.cmd_index) begin
            report($sformatf("command_index got %0d expected %0d",
                             got.cmd_index, want.cmd_index));
         end
         if (got.used_mask != want.used_mask) begin
            report($sformatf("used_mask got %b expected %b", got.used_mask, want.used_mask));
         end
         for (k = 0; k < FIELD_COUNT; k++) begin
            if (got.values[k] != want.values[k]) begin
               report($sformatf("%c value got %0d expected %0d", FIELD_LETTERS[k],
                                $signed(got.values[k]), $signed(want.values[k])));
            end
         end
         if (tdata[207:203] != '0) begin
            report($sformatf("padding bits got %b", tdata[207:203]));
         end
      endtask
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;

   gcode_line_predictor board;
   line_request_type    line_requests[$];
   logic [7:0]          line_buf[$];
   int                  cycle_count = 0;
   int                  rsp_stall   = 0;
   int                  rsp_calm    = 0;

   gcode_line_field_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [7:0] non_space_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE);
      return b;
   endfunction

   task automatic add_byte(logic [7:0] b);
      line_buf.push_back(b);
   endtask

   task automatic add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic add_spaces(int lo, int hi);
      repeat ($urandom_range(lo, hi)) line_buf.push_back(CHAR_SPACE);
   endtask

   // Move the collected line into the request list, marking its final byte.
   task automatic end_line();
      line_request_type item;
      int               i;
      if (line_buf.size() == 0) line_buf.push_back(CHAR_SPACE);
      for (i = 0; i < line_buf.size(); i++) begin
         item.line_byte = line_buf[i];
         item.line_end  = (i == line_buf.size() - 1);
         line_requests.push_back(item);
      end
      line_buf.delete();
   endtask

   task automatic line_text(string s);
      add_text(s);
      end_line();
   endtask

   // One field token with random letter, whitespace, sign, digits and tail.
   task automatic add_field();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 85) add_byte(FIELD_LETTERS[$urandom_range(0, FIELD_COUNT - 1)]);
      else add_byte(non_space_byte());
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(CHAR_TAB, CHAR_CR)));
      end
      r = $urandom_range(0, 9);
      if (r < 2) add_byte(CHAR_MINUS);
      else if (r < 3) add_byte(CHAR_PLUS);
      r = $urandom_range(0, 9);
      if (r == 0) n = 0;
      else if (r == 1) n = $urandom_range(8, 14);
      else n = $urandom_range(1, 6);
      repeat (n) add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) begin
         add_byte(non_space_byte());
         repeat ($urandom_range(0, 2)) add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
   endtask

   // Mostly well-formed lines with random content, some noise and bad names.
   task automatic make_random_line();
      int    r;
      string name;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         repeat ($urandom_range(1, 16)) begin
            if ($urandom_range(0, 4) == 0) add_byte(CHAR_SPACE);
            else add_byte(8'($urandom_range(0, 255)));
         end
      end else begin
         if ($urandom_range(0, 5) == 0) add_spaces(1, 3);
         name = board.cmd_names[$urandom_range(0, COMMAND_COUNT - 1)];
         if (r < 82) begin
            add_text(name);
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  add_text(name);
                  add_byte(non_space_byte());
               end
               1: add_text(name.tolower());
               2: add_text(name.substr(1, name.len() - 1));
               default: repeat ($urandom_range(1, 6)) add_byte(non_space_byte());
            endcase
         end
         repeat ($urandom_range(0, 7)) begin
            add_spaces(1, 3);
            add_field();
         end
         if ($urandom_range(0, 4) == 0) add_spaces(1, 2);
      end
      end_line();
   endtask

   task automatic build_lines();
      // Every command, field extremes and the documented corner cases.
      line_text("G1 X10 Y-20 Z+30 E0 F2147483647 S-2147483648");
      line_text("G28");
      line_text("G90 X1");
      line_text("G91 Y-1");
      line_text("G92 E0");
      line_text("M104 S200");
      line_text("M109 S210");
      line_text("M140 S60");
      line_text("M190 S60");
      line_text("M106 S255 F-0");
      line_text(" ");
      line_text("   ");
      line_text("G2 X1");
      line_text("M1040 S1");
      line_text("M104000 S1");
      add_text("G1");
      add_byte(CHAR_NUL);
      line_text(" X1");
      line_text("G1 X2147483648 Y-2147483649 Z99999999999999999999 E-99999999999999999999");
      line_text("G1 X\011\012-5 Y\013\014\0157 Z5\0116 E\011+8");
      line_text("G1 X Y- Z+ Ea F+-3 S--");
      line_text("G1 X1 X2 Y3 Y-4");
      line_text("G1 x5 A3 s7 Z1");
      line_text("  G1   X12-3   Y4.75  ");
      add_text("G1 X");
      add_byte(CHAR_NUL);
      add_text("5 ");
      add_byte(CHAR_NUL);
      line_text(" Z7");
      add_text("G1 X");
      add_byte(8'hFF);
      add_text(" Y");
      add_byte(8'h80);
      line_text("3");

      // Random lines follow until the request list holds the planned byte count.
      while (line_requests.size() < ITEM_COUNT) make_random_line();
   endtask

   // Offer each request byte with random gaps, waiting for the handshake.
   task automatic drive_requests();
      line_request_type item;
      int               gap;
      int               calm;
      calm = 0;
      while (line_requests.size() != 0) begin
         item = line_requests.pop_front();
         if (calm > 0) begin
            calm--;
            gap = 0;
         end else begin
            gap = gap_len();
            if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= item.line_byte;
         req_tlast  <= item.line_end;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         board.note_byte(item.line_byte, item.line_end);
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   // Result side back-pressure, with calm stretches of steady ready.
   always @(negedge clock) begin
      if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = gap_len();
         if ($urandom_range(0, 49) == 0) rsp_calm = $urandom_range(20, 80);
      end
   end

   // Check every accepted line result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_line(rsp_tdata);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      board = new();
      build_lines();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      drive_requests();
      while (board.expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> gcode_line_field_parser.f
rtl/gclp_pkg.sv
rtl/gclp_match.sv
rtl/gclp_scan.sv
rtl/gcode_line_field_parser.sv
tb/gcode_line_field_parser_tb.sv
